FILE: design/tft_command_pixel_stream_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the TFT command and pixel stream unit
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TFT_COMMAND_PIXEL_STREAM_UNIT_MACROS_SVH
`define TFT_COMMAND_PIXEL_STREAM_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define TCPS_ASSERT_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("tcps check failed");
`define TCPS_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("tcps check failed");
`else
`define TCPS_ASSERT_SAME(label, clk, rst_n, cond, prop)
`define TCPS_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

FILE: design/tcps_pkg.sv
// ----------------------------------------------------------------------------
// TFT command and pixel stream package
// Request and output types, command codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package tcps_pkg;

    typedef enum logic [1:0] {
        REQ_WINDOW = 2'd0,
        REQ_PIXEL  = 2'd1,
        REQ_GLYPH  = 2'd2,
        REQ_NONE   = 2'd3
    } req_type_t;

    typedef struct packed {
        req_type_t   req_type;
        logic [15:0] coord_x;
        logic [15:0] coord_y;
        logic [15:0] win_width;
        logic [15:0] win_height;
        logic [15:0] pixel_color;
        logic [7:0]  glyph_bits;
    } request_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       last_of_run;
    } out_item_t;

    typedef logic [7:0]  cfg_index_t;
    typedef logic [15:0] cfg_data_t;
    typedef logic [3:0]  byte_index_t;

    localparam cfg_index_t REG_X_OFFSET   = 8'd0;
    localparam cfg_index_t REG_Y_OFFSET   = 8'd1;
    localparam cfg_index_t REG_TEXT_COLOR = 8'd2;
    localparam cfg_index_t REG_BACK_COLOR = 8'd3;

    localparam logic [7:0] CMD_COLUMN_ADDR = 8'h2A;
    localparam logic [7:0] CMD_ROW_ADDR    = 8'h2B;
    localparam logic [7:0] CMD_MEM_WRITE   = 8'h2C;

    localparam logic [15:0] TEXT_COLOR_RESET = 16'hFFFF;

    localparam byte_index_t WIN_COL_CMD  = 4'd0;
    localparam byte_index_t WIN_SX_HI    = 4'd1;
    localparam byte_index_t WIN_SX_LO    = 4'd2;
    localparam byte_index_t WIN_EX_HI    = 4'd3;
    localparam byte_index_t WIN_EX_LO    = 4'd4;
    localparam byte_index_t WIN_ROW_CMD  = 4'd5;
    localparam byte_index_t WIN_SY_HI    = 4'd6;
    localparam byte_index_t WIN_SY_LO    = 4'd7;
    localparam byte_index_t WIN_EY_HI    = 4'd8;
    localparam byte_index_t WIN_EY_LO    = 4'd9;
    localparam byte_index_t WIN_LAST     = 4'd10;
    localparam byte_index_t PIXEL_LAST   = 4'd1;
    localparam byte_index_t GLYPH_LAST   = 4'd15;

endpackage

`default_nettype wire

FILE: design/tcps_if.sv
// ----------------------------------------------------------------------------
// TFT command and pixel stream interfaces
// Request, output byte and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcps_req_if;
    logic              valid;
    logic              ready;
    tcps_pkg::request_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tcps_out_if;
    logic                valid;
    logic                ready;
    tcps_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tcps_cfg_if;
    logic                 valid;
    logic                 ready;
    tcps_pkg::cfg_index_t index;
    tcps_pkg::cfg_data_t  wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

FILE: design/tft_command_pixel_stream_unit.sv
// ----------------------------------------------------------------------------
// TFT command and pixel stream unit
// Turns window, pixel and glyph requests into tagged panel link bytes.
// ----------------------------------------------------------------------------
// A request produces one byte per cycle, while the sink is ready, into a
// registered output stage: 11 bytes for a set-window request, 2 for a
// pixel request and 16 for a glyph-byte request, and a request of the
// unused type is taken with no output. The next request is accepted in the
// same cycle in which the last byte of the current one enters the output
// register, so throughput is set by the output register and the sink's pace.
`default_nettype none

`include "tft_command_pixel_stream_unit_macros.svh"

module tft_command_pixel_stream_unit (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tcps_req_if.sink    req,
    tcps_out_if.source  pix,
    tcps_cfg_if.sink    cfg
);

    logic [7:0]  x_offset_reg;
    logic [7:0]  y_offset_reg;
    logic [15:0] text_color_reg;
    logic [15:0] back_color_reg;

    logic                  cur_valid_reg;
    tcps_pkg::req_type_t   cur_type_reg;
    tcps_pkg::byte_index_t idx_reg;
    logic [15:0]           sx_reg;
    logic [15:0]           ex_reg;
    logic [15:0]           sy_reg;
    logic [15:0]           ey_reg;
    logic [15:0]           pixel_reg;
    logic [7:0]            glyph_reg;

    logic                  out_valid_reg;
    tcps_pkg::out_item_t   out_item_reg;

    logic                  out_free;
    logic                  advance;
    logic                  cur_last;
    logic                  req_fire;
    tcps_pkg::byte_index_t last_idx;
    logic [15:0]           sx_next;
    logic [15:0]           sy_next;
    logic [15:0]           ex_next;
    logic [15:0]           ey_next;
    logic [15:0]           glyph_color;
    tcps_pkg::out_item_t   item_next;

    assign out_free = !out_valid_reg || pix.ready;
    assign advance  = cur_valid_reg && out_free;
    assign cur_last = (idx_reg == last_idx);
    assign req.ready = !cur_valid_reg || (advance && cur_last);
    assign req_fire = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign pix.valid = out_valid_reg;
    assign pix.data  = out_item_reg;

    assign sx_next = req.data.coord_x + {8'd0, x_offset_reg};
    assign sy_next = req.data.coord_y + {8'd0, y_offset_reg};
    assign ex_next = sx_next + req.data.win_width - 16'd1;
    assign ey_next = sy_next + req.data.win_height - 16'd1;

    assign glyph_color = glyph_reg[idx_reg[3:1]] ? text_color_reg : back_color_reg;

    always_comb
    begin
        case (cur_type_reg)
            tcps_pkg::REQ_WINDOW: last_idx = tcps_pkg::WIN_LAST;
            tcps_pkg::REQ_PIXEL:  last_idx = tcps_pkg::PIXEL_LAST;
            default:              last_idx = tcps_pkg::GLYPH_LAST;
        endcase
    end

    always_comb
    begin
        item_next.is_data     = 1'b1;
        item_next.last_of_run = cur_last;
        case (cur_type_reg)
            tcps_pkg::REQ_WINDOW:
            begin
                case (idx_reg)
                    tcps_pkg::WIN_COL_CMD:
                    begin
                        item_next.out_byte = tcps_pkg::CMD_COLUMN_ADDR;
                        item_next.is_data  = 1'b0;
                    end
                    tcps_pkg::WIN_SX_HI: item_next.out_byte = sx_reg[15:8];
                    tcps_pkg::WIN_SX_LO: item_next.out_byte = sx_reg[7:0];
                    tcps_pkg::WIN_EX_HI: item_next.out_byte = ex_reg[15:8];
                    tcps_pkg::WIN_EX_LO: item_next.out_byte = ex_reg[7:0];
                    tcps_pkg::WIN_ROW_CMD:
                    begin
                        item_next.out_byte = tcps_pkg::CMD_ROW_ADDR;
                        item_next.is_data  = 1'b0;
                    end
                    tcps_pkg::WIN_SY_HI: item_next.out_byte = sy_reg[15:8];
                    tcps_pkg::WIN_SY_LO: item_next.out_byte = sy_reg[7:0];
                    tcps_pkg::WIN_EY_HI: item_next.out_byte = ey_reg[15:8];
                    tcps_pkg::WIN_EY_LO: item_next.out_byte = ey_reg[7:0];
                    default:
                    begin
                        item_next.out_byte = tcps_pkg::CMD_MEM_WRITE;
                        item_next.is_data  = 1'b0;
                    end
                endcase
            end
            tcps_pkg::REQ_PIXEL:
                item_next.out_byte = idx_reg[0] ? pixel_reg[7:0] : pixel_reg[15:8];
            default:
                item_next.out_byte = idx_reg[0] ? glyph_color[7:0] : glyph_color[15:8];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_offset_reg   <= 8'd0;
            y_offset_reg   <= 8'd0;
            text_color_reg <= tcps_pkg::TEXT_COLOR_RESET;
            back_color_reg <= 16'd0;
            cur_valid_reg  <= 1'b0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    tcps_pkg::REG_X_OFFSET:   x_offset_reg   <= cfg.wdata[7:0];
                    tcps_pkg::REG_Y_OFFSET:   y_offset_reg   <= cfg.wdata[7:0];
                    tcps_pkg::REG_TEXT_COLOR: text_color_reg <= cfg.wdata;
                    tcps_pkg::REG_BACK_COLOR: back_color_reg <= cfg.wdata;
                    default:                  ;
                endcase
            end

            if (req_fire)
            begin
                cur_valid_reg <= (req.data.req_type != tcps_pkg::REQ_NONE);
                idx_reg       <= '0;
            end
            else if (advance)
            begin
                idx_reg <= idx_reg + 4'd1;
                if (cur_last)
                begin
                    cur_valid_reg <= 1'b0;
                end
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pix.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            cur_type_reg <= req.data.req_type;
            sx_reg       <= sx_next;
            ex_reg       <= ex_next;
            sy_reg       <= sy_next;
            ey_reg       <= ey_next;
            pixel_reg    <= req.data.pixel_color;
            glyph_reg    <= req.data.glyph_bits;
        end
        if (advance)
        begin
            out_item_reg <= item_next;
        end
    end

    `TCPS_ASSERT_SAME(a_ready_only_on_last, clk, rst_n, req.ready && cur_valid_reg, advance && cur_last)
    `TCPS_ASSERT_NEXT(a_window_starts_at_zero, clk, rst_n, req_fire && req.data.req_type == tcps_pkg::REQ_WINDOW, cur_valid_reg && idx_reg == tcps_pkg::WIN_COL_CMD)
    `TCPS_ASSERT_SAME(a_window_index_range, clk, rst_n, cur_valid_reg && cur_type_reg == tcps_pkg::REQ_WINDOW, idx_reg <= tcps_pkg::WIN_LAST)
    `TCPS_ASSERT_SAME(a_pixel_index_range, clk, rst_n, cur_valid_reg && cur_type_reg == tcps_pkg::REQ_PIXEL, idx_reg <= tcps_pkg::PIXEL_LAST)
    `TCPS_ASSERT_NEXT(a_none_leaves_idle, clk, rst_n, req_fire && req.data.req_type == tcps_pkg::REQ_NONE, !cur_valid_reg)

endmodule

`default_nettype wire
